[hw/rtl/kmas_pkg.sv]
`timescale 1ns / 1ps

package kmas_pkg;

  // Fixed port widths.
  localparam int SAMPLE_W = 12;
  localparam int FS_W     = 12;
  localparam int LEVEL_W  = 16;
  localparam int SMOOTH_W = 12;

  // Divisor width of the level divider: covers 2 * full_scale.
  localparam int DEN_W = FS_W + 1;

  // Quotient bits the divider resolves per clock.
  localparam int DIV_BITS_PER_CYCLE = 2;

  localparam logic [FS_W-1:0]    FS_RESET  = 12'd4095;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

  // Access requests from the sequencer to the sample ring.
  typedef struct packed {
    logic rd;
    logic wr;
  } ring_ctl_t;

endpackage

[hw/rtl/kmas_ring.sv]
`timescale 1ns / 1ps

module kmas_ring
  import kmas_pkg::*;
#(
  parameter int WINDOW      = 20,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ring_ctl_t              ctl,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  output logic [SAMPLE_BITS-1:0] rd_data
);

  localparam int SLOT_W = $clog2(WINDOW);

  logic [SAMPLE_BITS-1:0] mem [WINDOW];
  logic [WINDOW-1:0]      valid;
  logic [SLOT_W-1:0]      slot;
  logic [SAMPLE_BITS-1:0] mem_q;
  logic                   vld_q;

  // Entries not yet written since reset read as zero.
  assign rd_data = vld_q ? mem_q : '0;

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      mem_q <= mem[slot];
    end
    if (ctl.wr) begin
      mem[slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      slot  <= '0;
      vld_q <= 1'b0;
    end else begin
      if (ctl.rd) begin
        vld_q <= valid[slot];
      end
      if (ctl.wr) begin
        valid[slot] <= 1'b1;
        slot        <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
      end
    end
  end

endmodule

[hw/rtl/kmas_div.sv]
`timescale 1ns / 1ps

module kmas_div
  import kmas_pkg::*;
#(
  parameter int DIV_W = 18
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int STEPS = DIV_W / DIV_BITS_PER_CYCLE;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DIV_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DIV_W-1:0] work_next;
  logic [DEN_W-1:0] rem_next;

  assign quotient = work;

  // Restoring division, a few quotient bits per clock. The quotient bits
  // shift into the bottom of the dividend register as it empties.
  always_comb begin
    logic [DEN_W:0] trial;
    rem_next  = rem;
    work_next = work;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      trial     = {rem_next, work_next[DIV_W-1]};
      work_next = {work_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_q}) begin
        rem_next     = DEN_W'(trial - {1'b0, divisor_q});
        work_next[0] = 1'b1;
      end else begin
        rem_next = trial[DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work      <= dividend;
      rem       <= '0;
      divisor_q <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

[hw/rtl/knob_moving_average_scaler_top.sv]
// Knob moving-average scaler. Each transfer on the input channel carries one raw
// knob reading; the block keeps the last WINDOW readings in a ring memory (zero
// after reset) and a running total, replaces the oldest reading, and returns one
// result transfer holding the boxcar average (total / WINDOW, rounded down) and
// the level in tenths, round-half-up of 10 * average / full_scale, computed as
// floor((20 * average + full_scale) / (2 * full_scale)) and saturated at 65535.
// The level is not clamped at ten. A full_scale of zero acts as one. One item is
// processed at a time. From input transfer to result valid it updates the total
// and writes the ring once the oldest reading has been read, forms the average by
// a multiply with the reciprocal of WINDOW, starts the level division, runs the
// serial divider at two quotient bits per clock until its done flag rises, and
// loads the output register. DIV_W is SAMPLE_BITS + 6 rounded up to even. The
// next input transfer can come in the cycle after the result is loaded. A new
// input is taken once the previous result sits in the output register, so
// a stalled consumer holds up at most one further item.
// The configuration channel is always ready and should only be written while
// the block is idle.
`timescale 1ns / 1ps

module knob_moving_average_scaler_top
  import kmas_pkg::*;
#(
  parameter int WINDOW      = 20,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [FS_W-1:0]     cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LEVEL_W-1:0]  level_tenths,
  output logic [SMOOTH_W-1:0] smoothed
);

  // The total of WINDOW samples never exceeds SAMPLE_BITS + clog2(WINDOW) bits,
  // and 20 * average + full_scale fits in SAMPLE_BITS + 6 bits.
  localparam int TOTAL_W = SAMPLE_BITS + $clog2(WINDOW);
  localparam int NUM_W   = SAMPLE_BITS + 6;
  localparam int DIV_W   = NUM_W + (NUM_W % DIV_BITS_PER_CYCLE);

  // The average is total * RECIP >> SHIFT, with RECIP = ceil(2^SHIFT / WINDOW).
  // With SHIFT = TOTAL_W + clog2(WINDOW) this is exact for every total.
  localparam int SHIFT   = TOTAL_W + $clog2(WINDOW);
  localparam int RECIP_W = TOTAL_W + 1;
  localparam int PROD_W  = TOTAL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_AVG   = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_LEVEL = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [FS_W-1:0]        full_scale;
  logic [SAMPLE_BITS-1:0] samp;
  logic [TOTAL_W-1:0]     total;
  logic [TOTAL_W-1:0]     total_next;
  logic [PROD_W-1:0]      avg_prod;
  logic [SAMPLE_BITS-1:0] avg;
  logic [SAMPLE_BITS-1:0] oldest;
  ring_ctl_t              ring_ctl;
  logic                   div_start;
  logic                   div_done;
  logic [DIV_W-1:0]       div_dividend;
  logic [DEN_W-1:0]       div_divisor;
  logic [DIV_W-1:0]       div_quot;
  logic [FS_W-1:0]        fs_eff;
  logic [DIV_W-1:0]       level_num;
  logic [LEVEL_W-1:0]     level_sat;
  logic                   out_free;
  logic                   in_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      full_scale <= cfg_data;
    end
  end

  // The ring is read when the sample arrives and written back in the cycle after,
  // once the evicted value is known. Only one item is in flight, so a read and
  // a write of the same slot never overlap.
  assign ring_ctl.rd = in_xfer;
  assign ring_ctl.wr = (state == ST_READ);

  kmas_ring #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ring_ctl),
    .wr_data (samp),
    .rd_data (oldest)
  );

  assign total_next = total - TOTAL_W'(oldest) + TOTAL_W'(samp);

  // Average of the window from the registered total.
  assign avg_prod = PROD_W'(total) * PROD_W'(RECIP);

  // Level dividend built from the registered average.
  assign fs_eff    = (full_scale == '0) ? FS_W'(1) : full_scale;
  assign level_num = (DIV_W'(avg) << 4)
                   + (DIV_W'(avg) << 2)
                   + DIV_W'(fs_eff);

  assign div_start    = (state == ST_START);
  assign div_dividend = level_num;
  assign div_divisor  = {fs_eff, 1'b0};

  kmas_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign level_sat = (|div_quot[DIV_W-1:LEVEL_W]) ? LEVEL_MAX : div_quot[LEVEL_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xfer) state_next = ST_READ;
      ST_READ:  state_next = ST_AVG;
      ST_AVG:   state_next = ST_START;
      ST_START: state_next = ST_LEVEL;
      ST_LEVEL: if (div_done) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      total <= '0;
    end else begin
      state <= state_next;
      if (state == ST_READ) begin
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      samp <= SAMPLE_BITS'(sample);
    end
    if (state == ST_AVG) begin
      avg <= avg_prod[SHIFT +: SAMPLE_BITS];
    end
  end

  // Output register: loaded from the held quotient when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      level_tenths <= level_sat;
      smoothed     <= SMOOTH_W'(avg);
    end
  end

endmodule

[hw/rtl/kmas_checker.sv]
`timescale 1ns / 1ps

module kmas_checker
  import kmas_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [LEVEL_W-1:0]  level_tenths,
  input logic [SMOOTH_W-1:0] smoothed
);

  // Items taken in but whose result has not yet been transferred out.
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'((in_valid && in_ready)) - 3'((out_valid && out_ready));
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level_tenths) && $stable(smoothed))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result with no item outstanding");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("more than two items outstanding");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is being processed");

endmodule

bind knob_moving_average_scaler_top kmas_checker u_kmas_checker (.*);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import kmas_pkg::*;

  // The block under test keeps its default window and sample width, and the
  // local predictor below is written for the same values.
  localparam int WINDOW      = 20;
  localparam int SAMPLE_BITS = 12;

  // Clock period in ns and the run limit in cycles. The slowest correct run
  // is about 1800 items plus two long receiver holds, so the limit leaves a
  // wide margin.
  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 400000;

  // Cycles to keep watching after the last expected result, so that a late
  // or spurious result transfer still gets caught.
  localparam int DRAIN_CYCLES = 40;

  // A long receiver hold starts when this many results have been seen, and
  // again every HOLD_EVERY results after that.
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_FIRST  = 300;
  localparam int HOLD_EVERY  = 900;

  // Each pending entry is either a knob reading for the input channel or a
  // new full scale value for the configuration channel.
  typedef enum logic {
    OP_READING,
    OP_SET_FULL_SCALE
  } knob_op_kind_t;

  typedef struct {
    knob_op_kind_t    kind;
    logic [FS_W-1:0]  value;
    int               gap;
  } knob_op_t;

  // One expected result transfer.
  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic [SMOOTH_W-1:0] average;
  } knob_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [FS_W-1:0]     cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LEVEL_W-1:0]  level_tenths;
  logic [SMOOTH_W-1:0] smoothed;

  // Work still to be offered, and results that the block still owes us.
  knob_op_t     pending_ops[$];
  knob_result_t owed_results[$];

  // Predictor state: the ring of recent readings, the slot that holds the
  // oldest one, their sum, and the full scale register as we last wrote it.
  logic [SAMPLE_W-1:0] ring_copy [WINDOW];
  int                  oldest_slot;
  int                  ring_sum;
  logic [FS_W-1:0]     full_scale_now;

  int error_count  = 0;
  int results_seen = 0;
  int hold_left    = 0;
  int next_hold_at = HOLD_FIRST;

  // Driver and monitor scratch variables.
  logic         next_in_valid;
  logic         next_cfg_valid;
  logic         next_out_ready;
  int           idle_cycles = 0;
  int           rx_wait     = 0;
  knob_result_t want;

  knob_moving_average_scaler_top #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .level_tenths (level_tenths),
    .smoothed     (smoothed)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Only the first ten failures are described in detail; the rest are
  // counted so the log stays short on a badly broken build.
  task automatic note_failure(input string what);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at %0t: %s", $realtime, what);
    end
  endtask

  // Pushes one reading through the predictor: the oldest reading leaves the
  // sum, the new one takes its slot, and the average and the level in tenths
  // follow. The level is floor((20 * avg + fs) / (2 * fs)), which is exact
  // round-half-up of 10 * avg / fs; a full scale of zero behaves as one.
  task automatic absorb_reading(input logic [SAMPLE_W-1:0] reading);
    int           fs;
    longint       quotient;
    knob_result_t res;
    ring_sum = ring_sum - int'(ring_copy[oldest_slot]) + int'(reading);
    ring_copy[oldest_slot] = reading;
    oldest_slot = (oldest_slot == WINDOW - 1) ? 0 : oldest_slot + 1;
    res.average = SMOOTH_W'(ring_sum / WINDOW);
    fs = (full_scale_now == '0) ? 1 : int'(full_scale_now);
    quotient = (20 * longint'(res.average) + fs) / (2 * fs);
    res.level = (quotient > longint'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(quotient);
    owed_results.push_back(res);
  endtask

  task automatic add_reading(input int value, input int gap);
    knob_op_t op;
    op.kind  = OP_READING;
    op.value = value[FS_W-1:0];
    op.gap   = gap;
    pending_ops.push_back(op);
  endtask

  task automatic add_full_scale(input int value);
    knob_op_t op;
    op.kind  = OP_SET_FULL_SCALE;
    op.value = value[FS_W-1:0];
    op.gap   = $urandom_range(0, 10);
    pending_ops.push_back(op);
  endtask

  // Driver. Completed transfers are folded into the predictor first, then
  // the next entry is offered once its idle gap has passed. A full scale
  // write waits until every owed result has come back, so the block is idle
  // when the register changes. Each valid gets exactly one assignment per
  // edge, so back-to-back transfers keep valid high without a glitch.
  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      cfg_valid   <= 1'b0;
      sample      <= '0;
      cfg_data    <= '0;
      idle_cycles = 0;
    end else begin
      next_in_valid  = in_valid;
      next_cfg_valid = cfg_valid;
      if (in_valid && in_ready) begin
        absorb_reading(sample);
        next_in_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        full_scale_now = cfg_data;
        next_cfg_valid = 1'b0;
      end
      if (!next_in_valid && !next_cfg_valid && pending_ops.size() != 0) begin
        if (idle_cycles < pending_ops[0].gap) begin
          idle_cycles++;
        end else if (pending_ops[0].kind == OP_READING) begin
          sample        <= pending_ops[0].value;
          next_in_valid = 1'b1;
          idle_cycles   = 0;
          void'(pending_ops.pop_front());
        end else if (owed_results.size() == 0) begin
          cfg_data       <= pending_ops[0].value;
          next_cfg_valid = 1'b1;
          idle_cycles    = 0;
          void'(pending_ops.pop_front());
        end
      end
      in_valid  <= next_in_valid;
      cfg_valid <= next_cfg_valid;
    end
  end

  // Long receiver hold, counted here on its own. While it runs the sender
  // keeps offering readings, so the output register fills and the block
  // has to push back on its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen == next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_EVERY;
    end
  end

  // Monitor. Every result transfer is checked against the oldest owed
  // result. After each transfer the receiver draws a short stall, except in
  // every third stretch of results, where it draws none, apart from a long hold.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          note_failure($sformatf("result level=%0d smoothed=%0d with nothing owed",
                                 level_tenths, smoothed));
        end else begin
          want = owed_results.pop_front();
          if (level_tenths !== want.level) begin
            note_failure($sformatf("result %0d: level_tenths expected %0d, got %0d",
                                   results_seen, want.level, level_tenths));
          end
          if (smoothed !== want.average) begin
            note_failure($sformatf("result %0d: smoothed expected %0d, got %0d",
                                   results_seen, want.average, smoothed));
          end
        end
        results_seen <= results_seen + 1;
        rx_wait = ((results_seen / 140) % 3 == 2) ? 0 : $urandom_range(0, 10);
      end
      if (hold_left != 0) begin
        next_out_ready = 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        next_out_ready = 1'b0;
      end else begin
        next_out_ready = 1'b1;
      end
      out_ready <= next_out_ready;
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin
    int fixed_fs [5];
    int phase;
    int n;
    int pos;
    int value;
    int gap;

    fixed_fs = '{1, 4095, 0, 2048, 4094};
    for (n = 0; n < WINDOW; n++) begin
      ring_copy[n] = '0;
    end
    oldest_slot    = 0;
    ring_sum       = 0;
    full_scale_now = FS_RESET;

    // Directed part, starting from the reset full scale. Zero, one and full
    // range, alternating bit patterns and the value just below full, then a
    // run of full-range readings: the average climbs slowly from the zeroed
    // ring toward full range.
    add_reading(0, 0);
    add_reading(1, 0);
    add_reading(4095, 0);
    add_reading(12'hAAA, 1);
    add_reading(12'h555, 0);
    add_reading(4094, 2);
    for (n = 0; n < 16; n++) begin
      add_reading(4095, $urandom_range(0, 3));
    end
    // Full scale of one: the high average reads far above ten, with no clamp.
    add_full_scale(1);
    add_reading(4095, 0);
    add_reading(4095, 0);
    // Full scale of zero must act exactly like one.
    add_full_scale(0);
    add_reading(4095, 0);
    add_reading(0, 0);

    // Random part in phases, each with its own full scale. The first few
    // phases use the extremes and a midpoint, later ones random values, and
    // every third of those a tiny full scale for very large levels. Readings
    // come as uniform noise, a knob resting with jitter, rail-to-rail jumps,
    // or a knob turned slowly. Every fourth phase the sender never idles.
    for (phase = 0; phase < 11; phase++) begin
      if (phase < 5) begin
        add_full_scale(fixed_fs[phase]);
      end else if (phase % 3 == 0) begin
        add_full_scale($urandom_range(1, 64));
      end else begin
        add_full_scale($urandom_range(0, 4095));
      end
      pos = $urandom_range(0, 4095);
      for (n = 0; n < 160; n++) begin
        gap = (phase % 4 == 3) ? 0 : $urandom_range(0, 10);
        case (phase % 4)
          0: value = $urandom_range(0, 4095);
          1: begin
            if ($urandom_range(0, 31) == 0) begin
              pos = $urandom_range(0, 4095);
            end
            value = pos + $urandom_range(0, 80) - 40;
          end
          2: begin
            if ($urandom_range(0, 3) == 0) begin
              value = $urandom_range(0, 4095);
            end else begin
              value = $urandom_range(0, 1) ? 4095 : 0;
            end
          end
          default: begin
            pos = (pos + $urandom_range(0, 60)) % 4096;
            value = pos + $urandom_range(0, 20) - 10;
          end
        endcase
        if (value < 0) begin
          value = 0;
        end else if (value > 4095) begin
          value = 4095;
        end
        add_reading(value, gap);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait until everything has been offered and answered, then watch a
    // little longer for anything the block should not have sent.
    while (pending_ops.size() != 0 || in_valid || cfg_valid || owed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && owed_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Hard limit on the run, in case the block stops answering.
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("testbench: done, errors");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/kmas_pkg.sv
hw/rtl/kmas_ring.sv
hw/rtl/kmas_div.sv
hw/rtl/knob_moving_average_scaler_top.sv
hw/rtl/kmas_checker.sv
sim/testbench.sv
